// File: hw/rtl/shsi_pkg.sv
// shsi_pkg: shared codes and controller/datapath interface structs
// for the string hash set insert block; no dependencies
package shsi_pkg;

    // result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_COLLISION = 2'd2;

    // fixed field widths
    localparam int BUCKET_OUT_W = 10;
    localparam int PREV_OUT_W   = 11;
    localparam int CFG_W        = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // controller to datapath commands
    typedef struct packed {
        logic       clr;      // clear one occupancy entry
        logic       take;     // take a name byte into the hash and buffer
        logic       div;      // one reduction step
        logic       look;     // read bucket occupancy and length
        logic       claim;    // store into a free bucket
        logic       copy_wr;  // write one copied byte
        logic       inc;      // advance byte index
        logic       set_st;   // record duplicate or collision
        logic [1:0] st;
        logic       emit;     // load the result register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic len_full;
        logic div_done;
        logic last_pend;
        logic used;
        logic len_eq;
        logic byte_eq;
        logic i_last;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/string_hash_set_insert.sv
// string_hash_set_insert: each kept byte is accepted and then reduced by one
// shift-subtract step per quotient bit, 15 for 1024 buckets; the last byte then
// goes through bucket lookup, a read and compare or copy per byte, and a load of
// the result. Bytes past the name limit are taken one per cycle. After reset the
// occupancy map is swept, one bucket per cycle, before bytes are taken.
// Depends on shsi_pkg, shsi_ctrl, shsi_dp, shsi_ram
module string_hash_set_insert import shsi_pkg::*; #(
    parameter int BUCKETS    = 1024,
    parameter int NAME_BYTES = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_name_byte,
    input  logic                    i_last_byte,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_status,
    output logic [BUCKET_OUT_W-1:0] o_bucket,
    output logic [PREV_OUT_W-1:0]   o_previous_bucket,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    shsi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_byte (i_last_byte),
        .o_ready     (o_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath
    shsi_dp #(.BUCKETS(BUCKETS), .NAME_BYTES(NAME_BYTES)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_name_byte       (i_name_byte),
        .i_last_byte       (i_last_byte),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_bucket          (o_bucket),
        .o_previous_bucket (o_previous_bucket)
    );
endmodule

// File: hw/rtl/shsi_ram.sv
// shsi_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module shsi_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                     i_wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                     o_rdata
);
    logic [W-1:0] r_mem [D];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/shsi_ctrl.sv
// shsi_ctrl: sequencing state machine for the string hash set insert
// depends on shsi_pkg
module shsi_ctrl import shsi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last_byte,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_LOOK  = 10'b0000001000,
        S_CHK   = 10'b0000010000,
        S_RD    = 10'b0000100000,
        S_CMP   = 10'b0001000000,
        S_CRD   = 10'b0010000000,
        S_CWR   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    if (!i_stat.len_full) begin
                        o_cmd.take = 1'b1;
                        n_state    = S_DIV;
                    end else if (i_last_byte) begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_done) n_state = i_stat.last_pend ? S_LOOK : S_IDLE;
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (!i_stat.used) begin
                    o_cmd.claim = 1'b1;
                    n_state     = S_CRD;
                end else if (!i_stat.len_eq) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_COLLISION;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (!i_stat.byte_eq) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_COLLISION;
                    n_state      = S_DONE;
                end else if (i_stat.i_last) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_DUPLICATE;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_CRD: n_state = S_CWR;
            S_CWR: begin
                o_cmd.copy_wr = 1'b1;
                if (i_stat.i_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = S_CRD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: hw/rtl/shsi_dp.sv
// shsi_dp: hash, name buffer, bucket table and result register
// depends on shsi_pkg and shsi_ram
module shsi_dp import shsi_pkg::*; #(
    parameter int BUCKETS    = 1024,
    parameter int NAME_BYTES = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic [7:0]              i_name_byte,
    input  logic                    i_last_byte,
    input  logic                    i_cfg_valid,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_ready,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [BUCKET_OUT_W-1:0] o_bucket,
    output logic [PREV_OUT_W-1:0]   o_previous_bucket
);
    localparam int HW   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam int MW   = $clog2(BUCKETS + 1);
    // quotient bits: the hash may come from a larger earlier modulus
    localparam int QW   = $clog2(31 * BUCKETS + 256);
    localparam int KW   = $clog2(QW);
    localparam int VW   = HW + QW;
    localparam int LW   = $clog2(BUCKETS + 1);
    localparam int LENW = $clog2(NAME_BYTES + 1);
    localparam int IW   = NAME_BYTES > 1 ? $clog2(NAME_BYTES) : 1;
    localparam int SD   = BUCKETS * NAME_BYTES;
    localparam int SAW  = SD > 1 ? $clog2(SD) : 1;
    localparam logic [LW-1:0] NO_ENTRY = LW'(BUCKETS);

    logic [CFG_W-1:0] r_bc;
    logic [MW-1:0]    m;
    logic [HW-1:0]    r_hash, r_clr;
    logic [VW-1:0]    r_val, n_val, d;
    logic [KW-1:0]    r_k;
    logic             r_last_pend;
    logic [LENW-1:0]  r_len;
    logic [IW-1:0]    r_i;
    logic [SAW-1:0]   r_base;
    logic [LW-1:0]    r_last_entry, r_prev;
    logic [1:0]       r_st;
    logic             r_out_valid;
    logic             used_rd, used_we, used_wd;
    logic [HW-1:0]    used_wa;
    logic [LENW-1:0]  slen_rd;
    logic [7:0]       in_rd, st_rd;

    // configuration register, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_bc <= i_cfg_data;
        end
    end

    // effective modulus
    assign m = (r_bc == '0 || 32'(r_bc) > 32'(BUCKETS)) ? MW'(BUCKETS) : MW'(r_bc);

    // one restoring reduction step
    always_comb begin
        d     = VW'(m) << r_k;
        n_val = (r_val >= d) ? r_val - d : r_val;
    end

    // hash, length and reduction control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_len       <= '0;
            r_k         <= '0;
            r_last_pend <= 1'b0;
            r_clr       <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.take) begin
                r_val       <= VW'({r_hash, 5'b0}) - VW'(r_hash) + VW'(i_name_byte);
                r_k         <= KW'(QW - 1);
                r_len       <= r_len + 1'b1;
                r_last_pend <= i_last_byte;
            end
            if (i_cmd.div) begin
                r_val <= n_val;
                r_k   <= r_k - 1'b1;
                if (r_k == '0) r_hash <= HW'(n_val);
            end
            if (i_cmd.emit) begin
                r_hash <= '0;
                r_len  <= '0;
            end
        end
    end

    // byte index and table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_entry <= NO_ENTRY;
            r_i          <= '0;
        end else begin
            if (i_cmd.look) begin
                r_i    <= '0;
                r_base <= SAW'(32'(r_hash) * 32'(NAME_BYTES));
            end
            if (i_cmd.inc) r_i <= r_i + 1'b1;
            if (i_cmd.claim) begin
                r_st         <= ST_INSERTED;
                r_prev       <= r_last_entry;
                r_last_entry <= LW'(r_hash);
            end
            if (i_cmd.set_st) begin
                r_st   <= i_cmd.st;
                r_prev <= NO_ENTRY;
            end
        end
    end

    // occupancy map: cleared by a sweep after reset
    assign used_we = i_cmd.clr || i_cmd.claim;
    assign used_wa = i_cmd.clr ? r_clr : r_hash;
    assign used_wd = !i_cmd.clr;

    shsi_ram #(.W(1), .D(BUCKETS)) u_used (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_wa),
        .i_wdata (used_wd),
        .i_raddr (r_hash),
        .o_rdata (used_rd)
    );

    shsi_ram #(.W(LENW), .D(BUCKETS)) u_slen (
        .i_clk   (i_clk),
        .i_we    (i_cmd.claim),
        .i_waddr (r_hash),
        .i_wdata (r_len),
        .i_raddr (r_hash),
        .o_rdata (slen_rd)
    );

    shsi_ram #(.W(8), .D(NAME_BYTES)) u_inname (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take),
        .i_waddr (r_len[IW-1:0]),
        .i_wdata (i_name_byte),
        .i_raddr (r_i),
        .o_rdata (in_rd)
    );

    shsi_ram #(.W(8), .D(SD)) u_names (
        .i_clk   (i_clk),
        .i_we    (i_cmd.copy_wr),
        .i_waddr (r_base + SAW'(r_i)),
        .i_wdata (in_rd),
        .i_raddr (r_base + SAW'(r_i)),
        .o_rdata (st_rd)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid       <= 1'b1;
            o_status          <= r_st;
            o_bucket          <= BUCKET_OUT_W'(r_hash);
            o_previous_bucket <= PREV_OUT_W'(r_prev);
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    assign o_valid = r_out_valid;

    // status back to the controller
    always_comb begin
        o_stat.clr_last  = (r_clr == HW'(BUCKETS - 1));
        o_stat.len_full  = (32'(r_len) >= 32'(NAME_BYTES));
        o_stat.div_done  = (r_k == '0);
        o_stat.last_pend = r_last_pend;
        o_stat.used      = used_rd;
        o_stat.len_eq    = (slen_rd == r_len);
        o_stat.byte_eq   = (st_rd == in_rd);
        o_stat.i_last    = (LENW'(r_i) + 1'b1 == r_len);
        o_stat.out_free  = !r_out_valid || i_ready;
    end
endmodule

// File: bench/testbench.sv
// testbench for string_hash_set_insert: drives names as byte transfers with random idling
// and checks each result against a behavioural predictor; depends on shsi_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
    import shsi_pkg::*;

    localparam int NB       = 1024;
    localparam int NMAX     = 256;
    localparam int NO_ENTRY = NB;
    localparam int LIMIT    = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_name_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [9:0]  o_bucket;
    logic [10:0] o_previous_bucket;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    string_hash_set_insert dut (.*);

    always #2 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  bucket;
        logic [10:0] prev;
    } t_result;

    // predictor state
    int unsigned   count_reg;
    int unsigned   acc;
    int unsigned   in_len;
    logic [7:0]    in_name [NMAX];
    bit            occupied [NB];
    logic [7:0]    table_names [NB][NMAX];
    int unsigned   table_lens [NB];
    int unsigned   tail;

    t_result pending_results [$];
    int      mismatches = 0;
    int      cycles = 0;
    int      send_idle = 23;
    int      recv_idle = 50;

    // one byte through the hash set; returns 1 when it ends a name
    function automatic bit predict_insert(input logic [7:0] b, input bit fin,
                                          output t_result r);
        int unsigned m, bk;
        bit same;
        m = (count_reg == 0 || count_reg > NB) ? NB : count_reg;
        if (in_len < NMAX) begin
            acc = (31 * acc + b) % m;
            in_name[in_len] = b;
            in_len++;
        end
        if (!fin) return 0;
        bk = acc % NB;
        r.bucket = bk[9:0];
        r.prev = NO_ENTRY;
        if (occupied[bk]) begin
            same = (table_lens[bk] == in_len);
            for (int i = 0; i < in_len && same; i++)
                if (table_names[bk][i] != in_name[i]) same = 0;
            r.status = same ? ST_DUPLICATE : ST_COLLISION;
        end else begin
            r.status = ST_INSERTED;
            r.prev = tail[10:0];
            occupied[bk] = 1;
            for (int i = 0; i < in_len; i++) table_names[bk][i] = in_name[i];
            table_lens[bk] = in_len;
            tail = bk;
        end
        acc = 0;
        in_len = 0;
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall, compare on each transfer
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_bucket, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status) report_mismatch("status", o_status, want.status);
                if (o_bucket != want.bucket) report_mismatch("bucket", o_bucket, want.bucket);
                if (o_previous_bucket != want.prev)
                    report_mismatch("previous_bucket", o_previous_bucket, want.prev);
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // one byte transfer with optional fixed expectation (status -1 means predictor)
    task automatic send_byte(input logic [7:0] b, input bit fin, input int fixed_st = -1,
                             input int fixed_bk = -1, input int fixed_prev = -1);
        t_result r;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_name_byte <= b;
        i_last_byte <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (predict_insert(b, fin, r)) begin
            if (fixed_st >= 0 && (r.status != fixed_st || r.bucket != fixed_bk
                                  || r.prev != fixed_prev))
                report_mismatch("table row vs predictor", r.bucket, fixed_bk);
            pending_results.push_back(r);
        end
    endtask

    task automatic send_name(input int len, input int alphabet);
        for (int i = 0; i < len; i++)
            send_byte(alphabet == 0 ? 8'($urandom) : 8'($urandom_range(alphabet)),
                      i == len - 1);
    endtask

    // wait until idle, then write the bucket count
    task automatic write_count(input logic [10:0] v);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        count_reg = v;
    endtask

    // directed rows: byte, last, fixed status/bucket/prev where obvious
    typedef struct {
        logic [7:0] b;
        bit         fin;
        int         st;
        int         bk;
        int         prev;
    } t_row;

    t_row rows [] = '{
        '{8'd0,   1, ST_INSERTED,  0,   NO_ENTRY},
        '{8'd0,   1, ST_DUPLICATE, 0,   NO_ENTRY},
        '{8'd255, 1, ST_INSERTED,  255, 0},
        '{8'd255, 1, ST_DUPLICATE, 255, NO_ENTRY},
        '{8'd0,   0, -1, -1, -1},
        '{8'd0,   1, ST_COLLISION, 0,   NO_ENTRY},
        '{8'd1,   0, -1, -1, -1},
        '{8'd2,   1, -1, -1, -1},
        '{8'd33,  1, ST_COLLISION, 33,  NO_ENTRY},
        '{8'd170, 0, -1, -1, -1},
        '{8'd85,  1, -1, -1, -1},
        '{8'd85,  0, -1, -1, -1},
        '{8'd170, 1, -1, -1, -1}
    };

    initial begin
        count_reg = 1024;
        acc = 0;
        in_len = 0;
        tail = NO_ENTRY;
        foreach (occupied[i]) occupied[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (rows[i]) send_byte(rows[i].b, rows[i].fin, rows[i].st, rows[i].bk,
                                    rows[i].prev);
        // overlong name, last mark past the limit
        for (int i = 0; i < NMAX + 3; i++) send_byte(8'($urandom), i == NMAX + 2);

        // settings: extremes, out-of-range, small moduli
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: write_count(11'd1);
                1: write_count(11'd0);
                2: write_count(11'd2047);
                3: write_count(11'd7);
                4: write_count(11'd1024);
                5: write_count(11'd1025);
                6: write_count(11'd13);
                7: write_count(11'd1023);
                default: write_count(11'(1 + $urandom_range(1023)));
            endcase
            if (phase == 3) begin send_idle = 50; recv_idle = 23; end
            if (phase == 6) begin send_idle = 0;  recv_idle = 0;  end
            for (int n = 0; n < 12; n++) begin
                // repeat a short name often to reach duplicates
                if ($urandom_range(3) == 0) begin
                    send_byte(8'($urandom_range(3)), 0);
                    send_byte(8'($urandom_range(3)), 1);
                end else begin
                    send_name(1 + $urandom_range(5), $urandom_range(1) ? 0 : 7);
                end
            end
        end
        // settle
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
